// File: design/ssfl_pkg.sv
// ---------------------------------------------------------------------------
// ssfl_pkg
// Shared types and constants of the substring search unit.
// ---------------------------------------------------------------------------
package ssfl_pkg;

   localparam int BYTE_W     = 8;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 2;
   localparam int CFG_LEN_W  = 5;
   localparam int IDX_W      = 17;

   typedef logic [BYTE_W-1:0]     byte_type;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [IDX_W-1:0]      index_type;

   localparam csr_addr_type CSR_PATTERN_LOW  = 2'd0;
   localparam csr_addr_type CSR_PATTERN_HIGH = 2'd1;
   localparam csr_addr_type CSR_PATTERN_LEN  = 2'd2;
   localparam csr_addr_type CSR_FROM_END     = 2'd3;

endpackage

// File: design/ssfl_cell.sv
// ---------------------------------------------------------------------------
// ssfl_cell
// One window cell: holds one text byte, passes it on to the next cell on a
// shift and compares it with the pattern byte that lines up with it.
// ---------------------------------------------------------------------------
module ssfl_cell #(
   parameter int PATTERN_MAX = 16,
   parameter int LEN_W       = 5,
   parameter int INDEX       = 0
) (
   input  logic                                clock,
   input  logic                                shift_en,
   input  ssfl_pkg::byte_type                  byte_in,
   input  logic [ssfl_pkg::BYTE_W*PATTERN_MAX-1:0] pattern,
   input  logic [LEN_W-1:0]                    len,
   output ssfl_pkg::byte_type                  byte_out,
   output logic                                eq
);
   import ssfl_pkg::*;

   byte_type         byte_ff;
   byte_type         byte_in_sel;
   byte_type         pat_sel;
   logic [LEN_W-1:0] pat_idx;

   assign byte_in_sel = shift_en ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_sel;
   end

   // cell k lines up with pattern byte len-1-k
   assign pat_idx = len - LEN_W'(1) - LEN_W'(INDEX);

   always_comb begin
      pat_sel = '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         if (pat_idx == LEN_W'(j)) begin
            pat_sel = pattern[BYTE_W*j +: BYTE_W];
         end
      end
   end

   assign eq       = (LEN_W'(INDEX) >= len) || (byte_ff == pat_sel);
   assign byte_out = byte_ff;

endmodule

// File: design/substring_search_first_last_unit.sv
// ---------------------------------------------------------------------------
// substring_search_first_last_unit
// Streaming substring search over a row of window cells, reporting the first
// or the last match of a configured pattern.
// ---------------------------------------------------------------------------
// Takes one text item per clock. Each present byte that fits within TEXT_MAX
// shifts into a row of PATTERN_MAX cells; in the following cycle every cell
// compares its byte with the pattern byte it lines up with and the match
// tracker records the start offset. The end-of-text result passes the compare
// stage into the output register. The input stalls only while a finished
// result is held there by rsp_stall and another end-of-text result is ready.
// ---------------------------------------------------------------------------
module substring_search_first_last_unit #(
   parameter int PATTERN_MAX = 16,
   parameter int TEXT_MAX    = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  ssfl_pkg::csr_addr_type csr_index,
   input  ssfl_pkg::csr_data_type csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ssfl_pkg::byte_type     req_text_byte,
   input  logic                   req_byte_present,
   input  logic                   req_end_of_text,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_match_found,
   output ssfl_pkg::index_type    rsp_match_index,
   output logic                   rsp_text_overflow
);
   import ssfl_pkg::*;

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int EXT_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
   localparam int POS_W = $clog2(TEXT_MAX + 1);
   localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;
   localparam int PAT_W = BYTE_W * PATTERN_MAX;

   // configuration
   csr_data_type         pat_low_ff;
   csr_data_type         pat_high_ff;
   logic [CFG_LEN_W-1:0] pat_len_ff;
   logic                 from_end_ff;

   logic [EXT_W-1:0]     len_ext;
   logic [LEN_W-1:0]     len;
   logic [PAT_W-1:0]     pat_vec;

   // intake stage
   logic                 req_accept;
   logic                 pos_room;
   logic                 do_shift;
   logic [POS_W-1:0]     pos_ff, pos_in, pos_next;
   logic                 ovf_ff, ovf_in, ovf_next;

   // compare stage
   logic                 b_valid_ff, b_shift_ff, b_end_ff, b_ovf_ff;
   logic [POS_W-1:0]     b_pos_ff;
   logic                 b_hold;
   logic                 b_fire;

   logic [PATTERN_MAX-1:0] cell_eq;
   byte_type               chain [PATTERN_MAX+1];

   logic                 hit;
   logic [CMP_W-1:0]     start_ext;
   logic [POS_W-1:0]     start;
   logic                 any_ff, any_in, any_next;
   logic [POS_W-1:0]     first_ff, first_in, first_next;
   logic [POS_W-1:0]     last_ff, last_in, last_next;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 found_ff, found_in;
   index_type            index_ff, index_in;
   logic                 rovf_ff, rovf_in;
   logic [POS_W-1:0]     idx_pos;

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= '0;
         from_end_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_wdata;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_wdata;
            CSR_PATTERN_LEN:  pat_len_ff  <= csr_wdata[CFG_LEN_W-1:0];
            CSR_FROM_END:     from_end_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign len_ext = (EXT_W'(pat_len_ff) > EXT_W'(PATTERN_MAX)) ?
                    EXT_W'(PATTERN_MAX) : EXT_W'(pat_len_ff);
   assign len     = len_ext[LEN_W-1:0];

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pat
      if (j < 8) begin : g_low
         assign pat_vec[BYTE_W*j +: BYTE_W] = pat_low_ff[BYTE_W*j +: BYTE_W];
      end else if (j < 16) begin : g_high
         assign pat_vec[BYTE_W*j +: BYTE_W] = pat_high_ff[BYTE_W*(j-8) +: BYTE_W];
      end else begin : g_zero
         assign pat_vec[BYTE_W*j +: BYTE_W] = '0;
      end
   end

   // ---- intake ----
   assign b_hold     = b_valid_ff && b_end_ff && rsp_valid_ff && rsp_stall;
   assign req_stall  = b_hold;
   assign req_accept = req_valid && !b_hold;
   assign pos_room   = (pos_ff != POS_W'(TEXT_MAX));
   assign do_shift   = req_accept && req_byte_present && pos_room;

   always_comb begin
      pos_next = do_shift ? POS_W'(pos_ff + 1'b1) : pos_ff;
      ovf_next = ovf_ff || (req_accept && req_byte_present && !pos_room);
      pos_in   = pos_ff;
      ovf_in   = ovf_ff;
      if (req_accept) begin
         pos_in = req_end_of_text ? '0 : pos_next;
         ovf_in = req_end_of_text ? 1'b0 : ovf_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         ovf_ff <= ovf_in;
      end
   end

   // ---- window cells ----
   assign chain[0] = req_text_byte;

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      ssfl_cell #(
         .PATTERN_MAX (PATTERN_MAX),
         .LEN_W       (LEN_W),
         .INDEX       (k)
      ) u_cell (
         .clock    (clock),
         .shift_en (do_shift),
         .byte_in  (chain[k]),
         .pattern  (pat_vec),
         .len      (len),
         .byte_out (chain[k+1]),
         .eq       (cell_eq[k])
      );
   end

   // ---- compare stage ----
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (!b_hold) begin
         b_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (!b_hold) begin
         b_shift_ff <= do_shift;
         b_end_ff   <= req_end_of_text;
         b_ovf_ff   <= ovf_next;
         b_pos_ff   <= pos_next;
      end
   end

   assign b_fire    = b_valid_ff && !b_hold;
   assign start_ext = CMP_W'(b_pos_ff) - CMP_W'(len);
   assign start     = start_ext[POS_W-1:0];
   assign hit       = b_shift_ff && (len != '0) &&
                      (CMP_W'(b_pos_ff) >= CMP_W'(len)) && (&cell_eq);

   always_comb begin
      any_next   = any_ff || hit;
      first_next = (hit && !any_ff) ? start : first_ff;
      last_next  = hit ? start : last_ff;
      any_in     = any_ff;
      first_in   = first_ff;
      last_in    = last_ff;
      if (b_fire) begin
         any_in   = b_end_ff ? 1'b0 : any_next;
         first_in = b_end_ff ? '0 : first_next;
         last_in  = b_end_ff ? '0 : last_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff   <= 1'b0;
         first_ff <= '0;
         last_ff  <= '0;
      end else begin
         any_ff   <= any_in;
         first_ff <= first_in;
         last_ff  <= last_in;
      end
   end

   // ---- result register ----
   always_comb begin
      if (len == '0) begin
         idx_pos = from_end_ff ? b_pos_ff : '0;
      end else if (any_next) begin
         idx_pos = from_end_ff ? last_next : first_next;
      end else begin
         idx_pos = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      found_in     = found_ff;
      index_in     = index_ff;
      rovf_in      = rovf_ff;
      if (b_fire && b_end_ff) begin
         rsp_valid_in = 1'b1;
         found_in     = (len == '0) || any_next;
         index_in     = IDX_W'(idx_pos);
         rovf_in      = b_ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      index_ff <= index_in;
      rovf_ff  <= rovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_match_found   = found_ff;
   assign rsp_match_index   = index_ff;
   assign rsp_text_overflow = rovf_ff;

endmodule
